// ----- rtl/i2c_master_transfer_sequencer_assert.svh -----
// assertion macros used by the checker file i2cms_port_chk.sv
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define I2CMS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("i2cms assertion failed");

// next-cycle implication, checked out of reset
`define I2CMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2cms assertion failed");

`endif

// ----- rtl/i2cms_pkg.sv -----
`default_nettype none

package i2cms_pkg;

  // item function codes
  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_START = 2'd1,
    FN_EVENT = 2'd2,
    FN_READ  = 2'd3
  } func_e;

  // transfer phase as reported on transfer_state
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BUSY  = 2'd1,
    PH_ERROR = 2'd2
  } phase_e;

  // configuration register indexes
  localparam logic CFG_SLAVE_ADDRESS = 1'b0;
  localparam logic CFG_BYTE_COUNT    = 1'b1;

  // master bus status codes
  localparam logic [7:0] ST_BUS_ERROR   = 8'h00;
  localparam logic [7:0] ST_START_SENT  = 8'h08;
  localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
  localparam logic [7:0] ST_ADDR_W_NACK = 8'h20;
  localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
  localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
  localparam logic [7:0] ST_ADDR_R_NACK = 8'h48;
  localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

endpackage

`default_nettype wire

// ----- rtl/i2c_master_transfer_sequencer.sv -----
// channel   direction  handshake                fields
// --------  ---------  -----------------------  ---------------------------------------
// in        to block   in_valid_i / in_stall_o  func, status_code, rx_byte, buffer_*
// out       from block out_valid_o/out_stall_i  requests, ack_next, tx_*, buffer_byte, state, count
// cfg       to block   cfg_we_i                 cfg_index_i, cfg_data_i
//
// one item per cycle sustained while the output is not stalled; a result reaches the outputs
// through the input and buffer read register, then the result register
// the buffer has a write port and two registered read ports, with bypass of the
// write done in the same cycle, so back-to-back items see each other's effects
// reset clears the pointer, count, phase, config registers and valids; buffer is not cleared
// a stalled output holds its beat and stalls the input once the input register is full
`default_nettype none

module i2c_master_transfer_sequencer #(
  parameter int unsigned BUFFER_DEPTH = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  // input channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] func_i,
  input  wire logic [7:0] status_code_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic [4:0] buffer_index_i,
  input  wire logic [7:0] buffer_data_i,
  // output channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            start_request_o,
  output logic            clear_start_o,
  output logic            stop_request_o,
  output logic            ack_next_o,
  output logic            tx_valid_o,
  output logic [7:0]      tx_byte_o,
  output logic [7:0]      buffer_byte_o,
  output logic [1:0]      transfer_state_o,
  output logic [5:0]      remaining_o
);

  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned PW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [8:0]    DEPTH_W = 9'(BUFFER_DEPTH);
  localparam logic [PW-1:0] PTR_END = PW'(BUFFER_DEPTH);
  localparam logic [5:0]    COUNT_MAX = 6'(BUFFER_DEPTH);

  // configuration registers
  logic [7:0] slave_address_q;
  logic [5:0] byte_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_address_q <= '0;
      byte_count_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        i2cms_pkg::CFG_SLAVE_ADDRESS: slave_address_q <= cfg_data_i;
        i2cms_pkg::CFG_BYTE_COUNT:    byte_count_q    <= cfg_data_i[5:0];
        default:                      slave_address_q <= slave_address_q;
      endcase
    end
  end

  // pipeline control
  logic s1_valid_q;
  logic out_valid_q;
  logic advance;
  logic commit;
  logic in_accept;

  assign advance   = !out_valid_q || !out_stall_i;
  assign commit    = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // sequencer state
  logic [PW-1:0]         ptr_q, ptr_nx;
  logic [5:0]            left_q, left_nx;
  i2cms_pkg::phase_e     phase_q, phase_nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      left_q  <= '0;
      phase_q <= i2cms_pkg::PH_IDLE;
    end else if (commit) begin
      ptr_q   <= ptr_nx;
      left_q  <= left_nx;
      phase_q <= phase_nx;
    end
  end

  // input register
  i2cms_pkg::func_e s1_func_q;
  logic [7:0]       s1_status_q;
  logic [7:0]       s1_rx_q;
  logic [4:0]       s1_idx_q;
  logic [7:0]       s1_data_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_func_q   <= i2cms_pkg::func_e'(func_i);
      s1_status_q <= status_code_i;
      s1_rx_q     <= rx_byte_i;
      s1_idx_q    <= buffer_index_i;
      s1_data_q   <= buffer_data_i;
    end
  end

  // buffer write port, driven by the committing item
  logic          wr_req;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  assign mem_we = commit && wr_req;

  // buffer read addresses for the beat being taken
  logic [7:0]    in_idx_ext;
  logic [AW-1:0] rd_idx_addr;
  logic [PW-1:0] rd_ptr_full;
  logic [AW-1:0] rd_ptr_addr;

  assign in_idx_ext  = {3'b000, buffer_index_i};
  assign rd_idx_addr = in_idx_ext[AW-1:0];
  assign rd_ptr_full = commit ? ptr_nx : ptr_q;
  assign rd_ptr_addr = rd_ptr_full[AW-1:0];

  // buffer memory with registered reads and write bypass
  logic [7:0] mem_q [BUFFER_DEPTH];
  logic [7:0] rd_idx_q;
  logic [7:0] rd_ptr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      rd_idx_q <= (mem_we && mem_waddr == rd_idx_addr) ? mem_wdata : mem_q[rd_idx_addr];
      rd_ptr_q <= (mem_we && mem_waddr == rd_ptr_addr) ? mem_wdata : mem_q[rd_ptr_addr];
    end
  end

  // item decode
  logic [7:0]    s1_idx_ext;
  logic          s1_idx_ok;
  logic          ptr_ok;
  logic [PW-1:0] ptr_inc;
  logic          start_d, clear_d, stop_d, ack_d, txv_d;
  logic [7:0]    txb_d, bufb_d;

  assign s1_idx_ext = {3'b000, s1_idx_q};
  assign s1_idx_ok  = {1'b0, s1_idx_ext} < DEPTH_W;
  assign ptr_ok     = ptr_q != PTR_END;
  assign ptr_inc    = ptr_q + PW'(1);

  always_comb begin
    ptr_nx    = ptr_q;
    left_nx   = left_q;
    phase_nx  = phase_q;
    wr_req    = 1'b0;
    mem_waddr = ptr_q[AW-1:0];
    mem_wdata = s1_rx_q;
    start_d   = 1'b0;
    clear_d   = 1'b0;
    stop_d    = 1'b0;
    ack_d     = 1'b0;
    txv_d     = 1'b0;
    txb_d     = '0;
    bufb_d    = '0;
    unique case (s1_func_q)
      i2cms_pkg::FN_LOAD: begin
        wr_req    = s1_idx_ok;
        mem_waddr = s1_idx_ext[AW-1:0];
        mem_wdata = s1_data_q;
      end
      i2cms_pkg::FN_START: begin
        left_nx  = ({3'b000, byte_count_q} < DEPTH_W) ? byte_count_q : COUNT_MAX;
        phase_nx = i2cms_pkg::PH_BUSY;
        start_d  = 1'b1;
      end
      i2cms_pkg::FN_READ: begin
        bufb_d = s1_idx_ok ? rd_idx_q : 8'h00;
      end
      i2cms_pkg::FN_EVENT: begin
        ack_d = 1'b1;
        unique case (s1_status_q)
          i2cms_pkg::ST_BUS_ERROR, i2cms_pkg::ST_ADDR_W_NACK: begin
            stop_d   = 1'b1;
            phase_nx = i2cms_pkg::PH_ERROR;
          end
          i2cms_pkg::ST_START_SENT: begin
            clear_d = 1'b1;
            txv_d   = 1'b1;
            txb_d   = slave_address_q;
            ptr_nx  = '0;
          end
          i2cms_pkg::ST_ADDR_W_ACK, i2cms_pkg::ST_DATA_W_ACK: begin
            if (left_q != 6'd0) begin
              txv_d   = 1'b1;
              left_nx = left_q - 6'd1;
              if (ptr_ok) begin
                txb_d  = rd_ptr_q;
                ptr_nx = ptr_inc;
              end
            end else begin
              stop_d   = 1'b1;
              phase_nx = i2cms_pkg::PH_IDLE;
            end
          end
          i2cms_pkg::ST_DATA_R_NACK: begin
            wr_req   = ptr_ok;
            ptr_nx   = ptr_ok ? ptr_inc : ptr_q;
            left_nx  = '0;
            stop_d   = 1'b1;
            phase_nx = i2cms_pkg::PH_IDLE;
          end
          i2cms_pkg::ST_DATA_W_NACK, i2cms_pkg::ST_ADDR_R_NACK: begin
            stop_d   = 1'b1;
            phase_nx = i2cms_pkg::PH_IDLE;
          end
          i2cms_pkg::ST_ADDR_R_ACK: begin
            wr_req    = 1'b1;
            mem_waddr = '0;
            ptr_nx    = '0;
            ack_d     = left_q != 6'd1;
          end
          i2cms_pkg::ST_DATA_R_ACK: begin
            wr_req = ptr_ok;
            ptr_nx = ptr_ok ? ptr_inc : ptr_q;
            if (left_q == 6'd0) begin
              stop_d   = 1'b1;
              phase_nx = i2cms_pkg::PH_IDLE;
            end else begin
              left_nx = left_q - 6'd1;
              ack_d   = left_q > 6'd2;
            end
          end
          default: begin
            ack_d = 1'b1;
          end
        endcase
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (commit) begin
      start_request_o  <= start_d;
      clear_start_o    <= clear_d;
      stop_request_o   <= stop_d;
      ack_next_o       <= ack_d;
      tx_valid_o       <= txv_d;
      tx_byte_o        <= txb_d;
      buffer_byte_o    <= bufb_d;
      transfer_state_o <= phase_nx;
      remaining_o      <= left_nx;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/i2cms_port_chk.sv -----
`default_nettype none

`include "i2c_master_transfer_sequencer_assert.svh"

module i2cms_port_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       start_request_o,
  input wire logic       clear_start_o,
  input wire logic       stop_request_o,
  input wire logic       ack_next_o,
  input wire logic       tx_valid_o,
  input wire logic [7:0] tx_byte_o,
  input wire logic [7:0] buffer_byte_o,
  input wire logic [1:0] transfer_state_o,
  input wire logic [5:0] remaining_o
);

  // output beat fields gathered for the checks
  logic [28:0] out_payload;
  logic [2:0]  bus_requests;
  logic        state_busy;

  assign out_payload  = {start_request_o, clear_start_o, stop_request_o, ack_next_o,
                         tx_valid_o, tx_byte_o, buffer_byte_o, transfer_state_o,
                         remaining_o};
  assign bus_requests = {start_request_o, clear_start_o, stop_request_o};
  assign state_busy   = transfer_state_o == i2cms_pkg::PH_BUSY;

  // a stalled output beat stays and holds its payload
  `I2CMS_ASSERT_NEXT(out_beat_held, out_valid_o && out_stall_i, out_valid_o)
  `I2CMS_ASSERT_NEXT(out_payload_held, out_valid_o && out_stall_i, $stable(out_payload))

  // at most one bus condition request per beat
  `I2CMS_ASSERT_IMPL(one_bus_request, out_valid_o, $onehot0(bus_requests))

  // a start beat always leaves the transfer busy
  `I2CMS_ASSERT_IMPL(start_means_busy, out_valid_o && start_request_o, state_busy)

endmodule

bind i2c_master_transfer_sequencer i2cms_port_chk u_port_chk (.*);

`default_nettype wire

// ----- test/i2c_master_transfer_sequencer_test.sv -----
`timescale 1ns / 1ps

module i2c_master_transfer_sequencer_test;

  localparam int unsigned BUF_DEPTH    = 32;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned LIMIT_CYCLES  = 400000;

  // status codes with no action of their own
  localparam logic [7:0] ST_RESTART_SENT = 8'h10;
  localparam logic [7:0] ST_RESERVED_14  = 8'h14;
  localparam logic [7:0] ST_NO_INFO      = 8'hFF;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] status_code;
    logic [7:0] rx_byte;
    logic [4:0] buffer_index;
    logic [7:0] buffer_data;
  } bus_item_t;

  typedef struct packed {
    logic       start_request;
    logic       clear_start;
    logic       stop_request;
    logic       ack_next;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [7:0] buffer_byte;
    logic [1:0] transfer_state;
    logic [5:0] remaining;
  } actions_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       cfg_we_i       = 1'b0;
  logic       cfg_index_i    = 1'b0;
  logic [7:0] cfg_data_i     = 8'h00;
  logic       in_valid_i     = 1'b0;
  logic       in_stall_o;
  logic [1:0] func_i         = 2'd0;
  logic [7:0] status_code_i  = 8'h00;
  logic [7:0] rx_byte_i      = 8'h00;
  logic [4:0] buffer_index_i = 5'd0;
  logic [7:0] buffer_data_i  = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i    = 1'b0;
  logic       start_request_o;
  logic       clear_start_o;
  logic       stop_request_o;
  logic       ack_next_o;
  logic       tx_valid_o;
  logic [7:0] tx_byte_o;
  logic [7:0] buffer_byte_o;
  logic [1:0] transfer_state_o;
  logic [5:0] remaining_o;

  i2c_master_transfer_sequencer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .status_code_i   (status_code_i),
    .rx_byte_i       (rx_byte_i),
    .buffer_index_i  (buffer_index_i),
    .buffer_data_i   (buffer_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .start_request_o (start_request_o),
    .clear_start_o   (clear_start_o),
    .stop_request_o  (stop_request_o),
    .ack_next_o      (ack_next_o),
    .tx_valid_o      (tx_valid_o),
    .tx_byte_o       (tx_byte_o),
    .buffer_byte_o   (buffer_byte_o),
    .transfer_state_o(transfer_state_o),
    .remaining_o     (remaining_o)
  );

  // sequencer shadow state
  logic [7:0]        shadow_buf [BUF_DEPTH];
  int unsigned       shadow_ptr;
  logic [5:0]        shadow_left;
  i2cms_pkg::phase_e shadow_phase;
  logic [7:0]        shadow_addr;
  logic [5:0]        shadow_count;

  actions_t    pending_actions [$];
  actions_t    head_actions;
  int          error_count    = 0;
  int          items_sent     = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int unsigned cycle_count    = 0;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic check_field(input string what, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // result beat checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_actions.size() == 0) begin
        report_mismatch("unexpected result beat", 8'h00, 8'h00);
      end else begin
        head_actions = pending_actions.pop_front();
        check_field("start_request", 8'(start_request_o),
                    8'(head_actions.start_request));
        check_field("clear_start", 8'(clear_start_o), 8'(head_actions.clear_start));
        check_field("stop_request", 8'(stop_request_o), 8'(head_actions.stop_request));
        check_field("ack_next", 8'(ack_next_o), 8'(head_actions.ack_next));
        check_field("tx_valid", 8'(tx_valid_o), 8'(head_actions.tx_valid));
        check_field("tx_byte", tx_byte_o, head_actions.tx_byte);
        check_field("buffer_byte", buffer_byte_o, head_actions.buffer_byte);
        check_field("transfer_state", 8'(transfer_state_o),
                    8'(head_actions.transfer_state));
        check_field("remaining", 8'(remaining_o), 8'(head_actions.remaining));
      end
    end
  end

  // received byte goes to the pointer slot unless the pointer ran off the end
  function automatic void store_at_ptr(input logic [7:0] value);
    if (shadow_ptr < BUF_DEPTH) begin
      shadow_buf[shadow_ptr] = value;
      shadow_ptr++;
    end
  endfunction

  // next bus actions for one item, updating the shadow state
  function automatic actions_t next_actions(input bus_item_t it);
    actions_t a;
    a = '0;
    case (it.func)
      i2cms_pkg::FN_LOAD:  shadow_buf[it.buffer_index] = it.buffer_data;
      i2cms_pkg::FN_START: begin
        shadow_left     = (shadow_count > BUF_DEPTH) ? 6'(BUF_DEPTH) : shadow_count;
        shadow_phase    = i2cms_pkg::PH_BUSY;
        a.start_request = 1'b1;
      end
      i2cms_pkg::FN_READ:  a.buffer_byte = shadow_buf[it.buffer_index];
      default: begin
        a.ack_next = 1'b1;
        case (it.status_code)
          i2cms_pkg::ST_BUS_ERROR, i2cms_pkg::ST_ADDR_W_NACK: begin
            a.stop_request = 1'b1;
            shadow_phase   = i2cms_pkg::PH_ERROR;
          end
          i2cms_pkg::ST_START_SENT: begin
            a.clear_start = 1'b1;
            a.tx_valid    = 1'b1;
            a.tx_byte     = shadow_addr;
            shadow_ptr    = 0;
          end
          i2cms_pkg::ST_ADDR_W_ACK, i2cms_pkg::ST_DATA_W_ACK: begin
            if (shadow_left != 0) begin
              a.tx_valid = 1'b1;
              if (shadow_ptr < BUF_DEPTH) begin
                a.tx_byte = shadow_buf[shadow_ptr];
                shadow_ptr++;
              end
              shadow_left--;
            end else begin
              a.stop_request = 1'b1;
              shadow_phase   = i2cms_pkg::PH_IDLE;
            end
          end
          i2cms_pkg::ST_DATA_R_NACK: begin
            store_at_ptr(it.rx_byte);
            shadow_left    = '0;
            a.stop_request = 1'b1;
            shadow_phase   = i2cms_pkg::PH_IDLE;
          end
          i2cms_pkg::ST_DATA_W_NACK, i2cms_pkg::ST_ADDR_R_NACK: begin
            a.stop_request = 1'b1;
            shadow_phase   = i2cms_pkg::PH_IDLE;
          end
          i2cms_pkg::ST_ADDR_R_ACK: begin
            shadow_buf[0] = it.rx_byte;
            shadow_ptr    = 0;
            if (shadow_left == 1) a.ack_next = 1'b0;
          end
          i2cms_pkg::ST_DATA_R_ACK: begin
            store_at_ptr(it.rx_byte);
            if (shadow_left == 0) begin
              a.stop_request = 1'b1;
              shadow_phase   = i2cms_pkg::PH_IDLE;
            end else begin
              shadow_left--;
              if (shadow_left <= 1) a.ack_next = 1'b0;
            end
          end
          default: ;
        endcase
      end
    endcase
    a.transfer_state = shadow_phase;
    a.remaining      = shadow_left;
    return a;
  endfunction

  function automatic bus_item_t make_item(input i2cms_pkg::func_e f, input logic [7:0] st);
    bus_item_t it;
    it.func         = f;
    it.status_code  = st;
    it.rx_byte      = 8'($urandom_range(0, 255));
    it.buffer_index = 5'($urandom_range(0, 31));
    it.buffer_data  = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // one input beat; valid stays high after acceptance
  task automatic send_item(input bus_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= it.func;
    status_code_i  <= it.status_code;
    rx_byte_i      <= it.rx_byte;
    buffer_index_i <= it.buffer_index;
    buffer_data_i  <= it.buffer_data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_actions.push_back(next_actions(it));
    items_sent++;
  endtask

  task automatic send_event(input logic [7:0] st);
    send_item(make_item(i2cms_pkg::FN_EVENT, st));
  endtask

  // stop sending and wait until every result beat is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic idx, input logic [7:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    if (idx == i2cms_pkg::CFG_SLAVE_ADDRESS) shadow_addr = data;
    else shadow_count = data[5:0];
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic randomize_config();
    int pick;
    logic [7:0] count_val;
    pick = $urandom_range(0, 99);
    if (pick < 50) count_val = 8'($urandom_range(0, 4));
    else if (pick < 70) count_val = 8'($urandom_range(5, 12));
    else if (pick < 85) count_val = 8'(BUF_DEPTH);
    else count_val = 8'($urandom_range(0, 255));
    drain_results();
    write_config(i2cms_pkg::CFG_SLAVE_ADDRESS, 8'($urandom_range(0, 255)));
    write_config(i2cms_pkg::CFG_BYTE_COUNT, count_val);
  endtask

  function automatic logic [7:0] pick_status();
    case ($urandom_range(0, 13))
      0:       return i2cms_pkg::ST_BUS_ERROR;
      1:       return i2cms_pkg::ST_START_SENT;
      2:       return i2cms_pkg::ST_ADDR_W_ACK;
      3:       return i2cms_pkg::ST_ADDR_W_NACK;
      4:       return i2cms_pkg::ST_DATA_W_ACK;
      5:       return i2cms_pkg::ST_DATA_W_NACK;
      6:       return i2cms_pkg::ST_ADDR_R_ACK;
      7:       return i2cms_pkg::ST_ADDR_R_NACK;
      8:       return i2cms_pkg::ST_DATA_R_ACK;
      9:       return i2cms_pkg::ST_DATA_R_NACK;
      10:      return ST_RESTART_SENT;
      11:      return ST_RESERVED_14;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // master write: address, n data bytes, stop on the last ack
  task automatic run_write_transfer();
    int n;
    int i;
    n = (shadow_count > BUF_DEPTH) ? BUF_DEPTH : shadow_count;
    send_item(make_item(i2cms_pkg::FN_START, 8'($urandom_range(0, 255))));
    if ($urandom_range(0, 9) != 0) send_event(i2cms_pkg::ST_START_SENT);
    if ($urandom_range(0, 19) == 0) begin
      send_event(i2cms_pkg::ST_ADDR_W_NACK);
      return;
    end
    send_event(i2cms_pkg::ST_ADDR_W_ACK);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 29) == 0) begin
        send_event(i2cms_pkg::ST_DATA_W_NACK);
        return;
      end
      send_event(i2cms_pkg::ST_DATA_W_ACK);
    end
  endtask

  // master read: address, n-1 acked bytes, nacked last byte
  task automatic run_read_transfer();
    int n;
    int i;
    n = (shadow_count > BUF_DEPTH) ? BUF_DEPTH : shadow_count;
    send_item(make_item(i2cms_pkg::FN_START, 8'($urandom_range(0, 255))));
    if ($urandom_range(0, 9) != 0) send_event(i2cms_pkg::ST_START_SENT);
    if ($urandom_range(0, 19) == 0) begin
      send_event(i2cms_pkg::ST_ADDR_R_NACK);
      return;
    end
    send_event(i2cms_pkg::ST_ADDR_R_ACK);
    for (i = 1; i < n; i++) send_event(i2cms_pkg::ST_DATA_R_ACK);
    // overrun past the count
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) send_event(i2cms_pkg::ST_DATA_R_ACK);
    end
    send_event(i2cms_pkg::ST_DATA_R_NACK);
  endtask

  // every entry written once so no read touches an unwritten one
  task automatic test_buffer_load();
    bus_item_t it;
    int i;
    for (i = 0; i < BUF_DEPTH; i++) begin
      it = make_item(i2cms_pkg::FN_LOAD, 8'($urandom_range(0, 255)));
      it.buffer_index = 5'(i);
      if (i == 0) it.buffer_data = 8'h00;
      else if (i == BUF_DEPTH - 1) it.buffer_data = 8'hFF;
      send_item(it);
    end
    it = make_item(i2cms_pkg::FN_READ, 8'h00);
    it.buffer_index = 5'd0;
    send_item(it);
    it = make_item(i2cms_pkg::FN_READ, 8'hFF);
    it.buffer_index = 5'd31;
    send_item(it);
  endtask

  task automatic test_write_transfer();
    drain_results();
    write_config(i2cms_pkg::CFG_SLAVE_ADDRESS, 8'h00);
    write_config(i2cms_pkg::CFG_BYTE_COUNT, 8'd2);
    send_item(make_item(i2cms_pkg::FN_START, 8'h00));
    send_event(i2cms_pkg::ST_START_SENT);
    send_event(i2cms_pkg::ST_ADDR_W_ACK);
    send_event(i2cms_pkg::ST_DATA_W_ACK);
    send_event(i2cms_pkg::ST_DATA_W_ACK);
  endtask

  task automatic test_read_transfer();
    drain_results();
    write_config(i2cms_pkg::CFG_SLAVE_ADDRESS, 8'hFF);
    write_config(i2cms_pkg::CFG_BYTE_COUNT, 8'd3);
    send_item(make_item(i2cms_pkg::FN_START, 8'hFF));
    send_event(i2cms_pkg::ST_START_SENT);
    send_event(i2cms_pkg::ST_ADDR_R_ACK);
    send_event(i2cms_pkg::ST_DATA_R_ACK);
    send_event(i2cms_pkg::ST_DATA_R_ACK);
    send_event(i2cms_pkg::ST_DATA_R_NACK);
  endtask

  // bus error, nacks, unknown codes, count limit and edge counts
  task automatic test_errors_and_limits();
    drain_results();
    write_config(i2cms_pkg::CFG_BYTE_COUNT, 8'hFF);
    send_item(make_item(i2cms_pkg::FN_START, 8'h00));
    send_event(i2cms_pkg::ST_BUS_ERROR);
    send_event(i2cms_pkg::ST_ADDR_W_NACK);
    send_event(i2cms_pkg::ST_DATA_W_NACK);
    send_event(i2cms_pkg::ST_ADDR_R_NACK);
    send_event(ST_RESTART_SENT);
    send_event(ST_RESERVED_14);
    send_event(ST_NO_INFO);
    drain_results();
    write_config(i2cms_pkg::CFG_BYTE_COUNT, 8'd0);
    send_item(make_item(i2cms_pkg::FN_START, 8'h00));
    send_event(i2cms_pkg::ST_DATA_R_ACK);
    drain_results();
    write_config(i2cms_pkg::CFG_BYTE_COUNT, 8'd1);
    send_item(make_item(i2cms_pkg::FN_START, 8'h00));
    send_event(i2cms_pkg::ST_ADDR_R_ACK);
    send_event(i2cms_pkg::ST_DATA_R_NACK);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_items);
    int stop_at;
    int pause_at;
    int pick;
    bit paused;
    bus_item_t it;
    drain_results();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at  = items_sent + n_items;
    pause_at = items_sent + n_items / 2;
    paused   = 1'b0;
    randomize_config();
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        run_write_transfer();
      end else if (pick < 70) begin
        run_read_transfer();
      end else if (pick < 80) begin
        it = make_item(($urandom_range(0, 1) != 0) ? i2cms_pkg::FN_LOAD : i2cms_pkg::FN_READ,
                       8'($urandom_range(0, 255)));
        send_item(it);
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 3)) begin
          it = make_item(i2cms_pkg::func_e'($urandom_range(0, 3)), pick_status());
          send_item(it);
        end
      end else begin
        randomize_config();
      end
      // hold off until the block has answered everything
      if (!paused && items_sent >= pause_at) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    shadow_ptr   = 0;
    shadow_left  = '0;
    shadow_phase = i2cms_pkg::PH_IDLE;
    shadow_addr  = '0;
    shadow_count = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_buffer_load();
    test_write_transfer();
    test_read_transfer();
    test_errors_and_limits();
    test_random_traffic(0, 0, 130);
    test_random_traffic(80, 0, 125);
    test_random_traffic(0, 80, 125);
    test_random_traffic(6, 6, 125);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/i2cms_pkg.sv
rtl/i2c_master_transfer_sequencer.sv
rtl/i2cms_port_chk.sv
test/i2c_master_transfer_sequencer_test.sv
